[hw/rtl/multi_stage_range_remap_unit_assert.svh]
// assertion macros shared by the range remap unit
`ifndef MULTI_STAGE_RANGE_REMAP_UNIT_ASSERT_SVH
`define MULTI_STAGE_RANGE_REMAP_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define MSRR_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("range remap check failed");

// condition holds in the cycle after the trigger
`define MSRR_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("range remap check failed");

`endif

[hw/rtl/msrr_pkg.sv]
// shared constants and controller/datapath interface types of the range remap unit
package msrr_pkg;

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_XLATE     = 2'd1;
    localparam logic [1:0] OP_CLR_MIN   = 2'd2;
    localparam logic [1:0] OP_CLR_TABLE = 2'd3;

    localparam int OP_W        = 2;
    localparam int STAGE_IDX_W = 3;
    localparam int ENTRY_IDX_W = 6;
    localparam int FIELD_W     = 40;
    localparam int CFG_W       = 4;

    localparam logic [CFG_W-1:0] STAGES_IN_USE_RESET = 4'd8;

    // input tdata layout, lowest field first
    localparam int IN_STAGE_LSB  = 0;
    localparam int IN_ENTRY_LSB  = IN_STAGE_LSB + STAGE_IDX_W;
    localparam int IN_SRC_LSB    = IN_ENTRY_LSB + ENTRY_IDX_W;
    localparam int IN_LEN_LSB    = IN_SRC_LSB + FIELD_W;
    localparam int IN_DEST_LSB   = IN_LEN_LSB + FIELD_W;
    localparam int IN_VALUE_LSB  = IN_DEST_LSB + FIELD_W;
    localparam int IN_USED_W     = IN_VALUE_LSB + FIELD_W;
    localparam int S_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_USED_W    = 2 * FIELD_W + 1;
    localparam int M_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = M_TDATA_W - OUT_USED_W;

    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic clr_run;    // write one entry of the clearing sweep
        logic issue;      // read the next entry of the current stage
        logic stage_adv;  // move on to the next stage
        logic out_load;   // load the result register
    } msrr_cmd_t;

    typedef struct packed {
        logic clr_last;    // sweep is at the final entry
        logic hit;         // checked entry matches the value
        logic scan_end;    // last entry checked without a match
        logic issue_done;  // all entries of the stage have been read
        logic last_stage;  // current stage is the last one in use
        logic no_stages;   // no stage in use
        logic out_busy;    // result register still held by the receiver
    } msrr_status_t;

endpackage

[hw/rtl/msrr_ctrl.sv]
// controller state machine of the range remap unit
module msrr_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [msrr_pkg::OP_W-1:0]   s_op,
    input  msrr_pkg::msrr_status_t      status,
    output msrr_pkg::msrr_cmd_t         cmd
);
    import msrr_pkg::*;

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;
    logic       stage_done;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign stage_done = status.hit || status.scan_end;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.accept    = accept;
        case (state_reg)
            ST_CLR: begin
                cmd.clr_run = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_op)
                        OP_CLR_TABLE: state_next = ST_CLR;
                        OP_XLATE:     state_next = status.no_stages ? ST_FIN : ST_SCAN;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.issue = !stage_done && !status.issue_done;
                if (stage_done) begin
                    if (status.last_stage) begin
                        state_next = ST_FIN;
                    end else begin
                        cmd.stage_adv = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/msrr_dp.sv]
// datapath of the range remap unit: entry memory, scan counters, value and result registers
module msrr_dp #(
    parameter int STAGES     = 8,
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 40
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  msrr_pkg::msrr_cmd_t              cmd,
    output msrr_pkg::msrr_status_t           status,
    input  logic [msrr_pkg::OP_W-1:0]        s_op,
    input  logic [msrr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             cfg_we,
    input  logic [msrr_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [msrr_pkg::M_TDATA_W-1:0]   m_tdata
);
    import msrr_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int SLOTS  = STAGES * ENTRIES;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW     = $clog2(ENTRIES + 1);
    localparam int SW     = $clog2(STAGES + 1);
    localparam int WORD_W = 3 * VB + 3;
    // word layout: valid, first, last, shift
    localparam int W_FIRST = 1;
    localparam int W_LAST  = W_FIRST + VB;
    localparam int W_SHIFT = W_LAST + VB + 1;
    localparam logic [4:0] STAGES_C = 5'(STAGES);

    logic [WORD_W-1:0] mem [SLOTS];
    logic [WORD_W-1:0] rd_word_reg;

    logic [CFG_W-1:0]  stages_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [EW-1:0]     entry_reg;
    logic [SW-1:0]     stage_reg;
    logic              chk_valid_reg;
    logic              chk_last_reg;
    logic [VB-1:0]     value_reg;
    logic              sat_reg;
    logic [VB-1:0]     min_reg;
    logic              out_valid_reg;
    logic [FIELD_W-1:0] out_tr_reg;
    logic [FIELD_W-1:0] out_min_reg;
    logic              out_sat_reg;

    // input fields
    logic [STAGE_IDX_W-1:0] in_stage;
    logic [ENTRY_IDX_W-1:0] in_entry;
    logic [VB-1:0]          in_src, in_len, in_dest, in_value;

    assign in_stage = s_tdata[IN_STAGE_LSB +: STAGE_IDX_W];
    assign in_entry = s_tdata[IN_ENTRY_LSB +: ENTRY_IDX_W];
    assign in_src   = VB'(s_tdata[IN_SRC_LSB +: FIELD_W]);
    assign in_len   = VB'(s_tdata[IN_LEN_LSB +: FIELD_W]);
    assign in_dest  = VB'(s_tdata[IN_DEST_LSB +: FIELD_W]);
    assign in_value = VB'(s_tdata[IN_VALUE_LSB +: FIELD_W]);

    logic              acc_load, acc_xlate, acc_clrmin, acc_clrtab;
    logic              idx_ok, load_wr;
    logic [ADDR_W-1:0] load_addr, wr_addr, rd_addr;
    logic [WORD_W-1:0] load_word, wr_word;
    logic [VB:0]       load_last, load_shift;

    assign acc_load   = cmd.accept && (s_op == OP_LOAD);
    assign acc_xlate  = cmd.accept && (s_op == OP_XLATE);
    assign acc_clrmin = cmd.accept && (s_op == OP_CLR_MIN);
    assign acc_clrtab = cmd.accept && (s_op == OP_CLR_TABLE);

    assign idx_ok    = (32'(in_stage) < 32'(STAGES)) && (32'(in_entry) < 32'(ENTRIES));
    assign load_wr   = acc_load && idx_ok;
    assign load_addr = ADDR_W'(32'(in_stage) * 32'(ENTRIES) + 32'(in_entry));
    assign load_last  = {1'b0, in_src} + {1'b0, in_len} - {{VB{1'b0}}, 1'b1};
    assign load_shift = {1'b0, in_dest} - {1'b0, in_src};
    assign load_word  = {load_shift, load_last, in_src, (in_len != '0)};

    assign wr_addr = cmd.clr_run ? clr_cnt_reg : load_addr;
    assign wr_word = cmd.clr_run ? '0 : load_word;
    assign rd_addr = base_reg + ADDR_W'(entry_reg);

    always_ff @(posedge aclk) begin
        if (cmd.clr_run || load_wr) begin
            mem[wr_addr] <= wr_word;
        end
        if (cmd.issue) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // match and shift of the entry read last cycle
    logic [VB:0]   rd_first, rd_last, rd_shift, sum;
    logic          rd_valid, hit, ovf;
    logic [VB-1:0] value_new;

    assign rd_valid  = rd_word_reg[0];
    assign rd_first  = {1'b0, rd_word_reg[W_FIRST +: VB]};
    assign rd_last   = rd_word_reg[W_LAST +: VB + 1];
    assign rd_shift  = rd_word_reg[W_SHIFT +: VB + 1];
    assign hit       = chk_valid_reg && rd_valid &&
                       (rd_first <= {1'b0, value_reg}) && ({1'b0, value_reg} <= rd_last);
    assign sum       = {1'b0, value_reg} + rd_shift;
    assign ovf       = sum[VB];
    assign value_new = ovf ? {VB{1'b1}} : sum[VB-1:0];

    logic [4:0]    n_eff, stage_plus;
    logic [VB-1:0] min_next;

    assign n_eff      = ({1'b0, stages_reg} > STAGES_C) ? STAGES_C : {1'b0, stages_reg};
    assign stage_plus = 5'(stage_reg) + 5'd1;
    assign min_next   = (value_reg < min_reg) ? value_reg : min_reg;

    assign status.clr_last   = (clr_cnt_reg == ADDR_W'(SLOTS - 1));
    assign status.hit        = hit;
    assign status.scan_end   = chk_valid_reg && chk_last_reg && !hit;
    assign status.issue_done = (entry_reg == EW'(ENTRIES));
    assign status.last_stage = (stage_plus >= n_eff);
    assign status.no_stages  = (stages_reg == '0);
    assign status.out_busy   = out_valid_reg && !m_tready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stages_reg    <= STAGES_IN_USE_RESET;
            clr_cnt_reg   <= '0;
            base_reg      <= '0;
            entry_reg     <= '0;
            stage_reg     <= '0;
            chk_valid_reg <= 1'b0;
            min_reg       <= {VB{1'b1}};
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                stages_reg <= cfg_data;
            end
            if (acc_clrtab) begin
                clr_cnt_reg <= '0;
            end else if (cmd.clr_run) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (acc_xlate) begin
                base_reg  <= '0;
                stage_reg <= '0;
                entry_reg <= '0;
            end else if (cmd.stage_adv) begin
                base_reg  <= base_reg + ADDR_W'(ENTRIES);
                stage_reg <= stage_reg + SW'(1);
                entry_reg <= '0;
            end else if (cmd.issue) begin
                entry_reg <= entry_reg + EW'(1);
            end
            chk_valid_reg <= cmd.issue;
            if (acc_clrmin) begin
                min_reg <= {VB{1'b1}};
            end else if (cmd.out_load) begin
                min_reg <= min_next;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        chk_last_reg <= (entry_reg == EW'(ENTRIES - 1));
        if (acc_xlate) begin
            value_reg <= in_value;
            sat_reg   <= 1'b0;
        end else if (hit) begin
            value_reg <= value_new;
            sat_reg   <= sat_reg | ovf;
        end
        if (cmd.out_load) begin
            out_tr_reg  <= FIELD_W'(value_reg);
            out_min_reg <= FIELD_W'(min_next);
            out_sat_reg <= sat_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_sat_reg, out_min_reg, out_tr_reg};

endmodule

[hw/rtl/multi_stage_range_remap_unit.sv]
// top level of the multi-stage range remap unit
//
// s_ channel: one item per handshake, op in s_tuser; load, translate, clear minimum
//   or clear table. only translate items produce a result item on the m_ channel.
// cfg channel: writes stages_in_use (reset 8); always ready, write it while idle.
// a translate item walks the entry memory one entry per cycle, stage after stage;
//   a stage ends at its first matching entry, or after its last entry when none
//   matches; the single read port of the entry memory sets this pace.
// load and clear-minimum items leave the unit idle; a clear-table item starts a sweep
//   over all STAGES*ENTRIES entries that invalidates every entry.
// after reset the same sweep runs first, with s_tready low;
//   configuration writes are still taken.
// the result sits in an output register: new items are accepted while it waits,
//   a second translate finishes and then holds until m_tready frees the register.
module multi_stage_range_remap_unit #(
    parameter int STAGES     = 8,
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 40
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input item channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // stage_index[2:0], entry_index[8:3], source_start[48:9], range_length[88:49],
    // dest_start[128:89], value[168:129], zero padding above
    input  logic [msrr_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[1:0]
    input  logic [msrr_pkg::OP_W-1:0]        s_tuser,
    // result item channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // translated[39:0], minimum[79:40], saturated[80], zero padding above
    output logic [msrr_pkg::M_TDATA_W-1:0]   m_tdata,
    // configuration write channel, stages_in_use
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [msrr_pkg::CFG_W-1:0]       cfg_data
);
    import msrr_pkg::*;

`include "multi_stage_range_remap_unit_assert.svh"

    msrr_cmd_t    cmd;
    msrr_status_t status;

    // register port never stalls
    assign cfg_ready = 1'b1;

    // sequencing: clearing sweep, accept, per-stage scan, result hand-over
    msrr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // entry memory, match and shift, running minimum, result register
    msrr_dp #(
        .STAGES     (STAGES),
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_op     (s_tuser),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    // no item is taken during the clearing sweep
    `MSRR_ASSERT_SAME(a_no_accept_in_sweep, cmd.clr_run, !s_tready)
    // the result register is only loaded when it is free or being emptied
    `MSRR_ASSERT_SAME(a_out_load_free, cmd.out_load, !m_tvalid || m_tready)
    // a loaded result is offered in the next cycle
    `MSRR_ASSERT_NEXT(a_out_shown, cmd.out_load, m_tvalid)
    // no entry read is in flight across a stage change
    `MSRR_ASSERT_SAME(a_no_read_on_adv, cmd.stage_adv, !cmd.issue)

endmodule
